/* src/lfw_pkg.sv */
package lfw_pkg;

  // fixed field widths
  localparam int CHAR_W = 8;
  localparam int COL_W  = 8;

  // defaults
  localparam int              WINDOW_DEFAULT   = 10;
  localparam logic [COL_W-1:0] LINE_WIDTH_RESET = 8'd40;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BLANK   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_HYPHEN  = 8'd45;

  // which symbol goes into the output register
  typedef enum logic [1:0] {
    SYM_CUR,
    SYM_NL,
    SYM_HY
  } sym_sel_t;

  // controller to datapath
  typedef struct packed {
    logic     cap;
    logic     step;
    logic     rd;
    logic     pop;
    logic     ld_buf;
    logic     ld_sym;
    sym_sel_t sym_sel;
    logic     out_last;
    logic     clear;
    logic     fold_fin;
    logic     cnt_ld_e;
    logic     cnt_dec;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_nl;
    logic pass;
    logic fold;
    logic fold_blank;
    logic cnt_zero;
    logic cnt_one;
    logic e_zero;
    logic out_free;
  } stat_t;

endpackage

/* src/lfw_in_if.sv */
interface lfw_in_if;
  logic                      valid;
  logic                      ready;
  logic [lfw_pkg::CHAR_W-1:0] in_char;

  modport source (output valid, output in_char, input ready);
  modport sink (input valid, input in_char, output ready);
endinterface

/* src/lfw_out_if.sv */
interface lfw_out_if;
  logic                      valid;
  logic                      ready;
  logic [lfw_pkg::CHAR_W-1:0] out_char;
  logic                      last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink (input valid, input out_char, input last, output ready);
endinterface

/* src/line_fold_wrap_top.sv */
// Line folder: takes one character word at a time and emits the text folded
// at line_width columns, breaking at the last blank or tab of the final
// WINDOW+1 columns, or with a hyphen when there is none. A character that
// passes straight through is captured, then decided and loaded into the
// output register, with a stall while that register is still full; a
// character that is only held gives no word. A fold or a newline flushes the
// hold buffer, which is a single-port memory with registered read, so each
// buffered character is read, then loaded, and each newline or hyphen is
// inserted directly; no input is taken during a fold or flush. The output
// register lets the next character be accepted while the last word still
// waits downstream. line_width is written through cfg_we and cfg_wdata; the
// user must write it only while the block is idle, the block does not enforce this.
module line_fold_wrap_top #(
  parameter int WINDOW = lfw_pkg::WINDOW_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lfw_pkg::COL_W-1:0] cfg_wdata,
  lfw_in_if.sink                    char_in,
  lfw_out_if.source                 char_out
);

  lfw_pkg::cmd_t  cmd;
  lfw_pkg::stat_t stat;

  lfw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (char_in.valid),
    .in_ready (char_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfw_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_char   (char_in.in_char),
    .out_ready (char_out.ready),
    .out_valid (char_out.valid),
    .out_char  (char_out.out_char),
    .out_last  (char_out.last),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* src/lfw_ctrl.sv */
module lfw_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lfw_pkg::stat_t stat,
  output lfw_pkg::cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_PASS_OUT,
    S_RUN,
    S_FETCH,
    S_DROP,
    S_HYPH,
    S_NL_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_NEWLINE,
    PH_BLANK,
    PH_HYPHEN,
    PH_CARRY
  } phase_t;

  state_t state, state_next;
  phase_t phase, phase_next;

  // no word is taken while reset is held
  assign in_ready = (state == S_IDLE) && !rst;

  // sequencing and commands
  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cmd          = '0;
    cmd.sym_sel  = lfw_pkg::SYM_CUR;
    case (state)
      S_IDLE: begin
        if (in_valid && !rst) begin
          cmd.cap    = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.step = 1'b1;
        if (stat.is_nl) begin
          phase_next = PH_NEWLINE;
          state_next = S_RUN;
        end else if (stat.pass) begin
          if (stat.out_free) begin
            cmd.ld_sym   = 1'b1;
            cmd.sym_sel  = lfw_pkg::SYM_CUR;
            cmd.out_last = 1'b1;
            state_next   = S_IDLE;
          end else begin
            state_next = S_PASS_OUT;
          end
        end else if (stat.fold) begin
          phase_next = stat.fold_blank ? PH_BLANK : PH_HYPHEN;
          state_next = S_RUN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PASS_OUT: begin
        if (stat.out_free) begin
          cmd.ld_sym   = 1'b1;
          cmd.sym_sel  = lfw_pkg::SYM_CUR;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_RUN: begin
        if (stat.cnt_zero) begin
          case (phase)
            PH_NEWLINE: state_next = S_NL_OUT;
            PH_BLANK:   state_next = S_DROP;
            PH_HYPHEN:  state_next = S_HYPH;
            default:    state_next = S_IDLE;
          endcase
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        if (stat.out_free) begin
          cmd.ld_buf   = 1'b1;
          cmd.out_last = (phase == PH_CARRY) && stat.cnt_one;
          cmd.pop      = 1'b1;
          cmd.cnt_dec  = 1'b1;
          state_next   = S_RUN;
        end
      end
      S_DROP: begin
        // the break blank itself is replaced by the newline
        cmd.pop    = 1'b1;
        state_next = S_NL_OUT;
      end
      S_HYPH: begin
        if (stat.out_free) begin
          cmd.ld_sym  = 1'b1;
          cmd.sym_sel = lfw_pkg::SYM_HY;
          state_next  = S_NL_OUT;
        end
      end
      S_NL_OUT: begin
        if (stat.out_free) begin
          cmd.ld_sym   = 1'b1;
          cmd.sym_sel  = lfw_pkg::SYM_NL;
          cmd.out_last = (phase == PH_NEWLINE) || stat.e_zero;
          if (phase == PH_NEWLINE) begin
            cmd.clear  = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.fold_fin = 1'b1;
            cmd.cnt_ld_e = 1'b1;
            if (stat.e_zero) begin
              state_next = S_IDLE;
            end else begin
              phase_next = PH_CARRY;
              state_next = S_RUN;
            end
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_NEWLINE;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

endmodule

/* src/lfw_dp.sv */
module lfw_dp #(
  parameter int WINDOW = lfw_pkg::WINDOW_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [lfw_pkg::COL_W-1:0]  cfg_wdata,
  input  logic [lfw_pkg::CHAR_W-1:0] in_char,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [lfw_pkg::CHAR_W-1:0] out_char,
  output logic                       out_last,
  input  lfw_pkg::cmd_t              cmd,
  output lfw_pkg::stat_t             stat
);

  localparam int DEPTH = WINDOW + 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int SW    = $clog2(2 * DEPTH);
  localparam int COLW  = lfw_pkg::COL_W;
  localparam logic [COLW-1:0] DEPTH_C = COLW'(DEPTH);
  localparam logic [COLW-1:0] WIN_C   = COLW'(WINDOW);
  localparam logic [CW-1:0]   FULL_C  = CW'(DEPTH);

  // configuration and line state
  logic [COLW-1:0]           line_width;
  logic [COLW-1:0]           col;
  logic                      wact;
  logic [IW-1:0]             hd;
  logic [CW-1:0]             hc;
  logic [CW-1:0]             brel;
  logic                      bseen;
  logic [CW-1:0]             cnt;
  logic [CW-1:0]             t_reg;
  logic [CW-1:0]             e_reg;
  logic [lfw_pkg::CHAR_W-1:0] cur;

  // circular hold buffer
  logic [lfw_pkg::CHAR_W-1:0] mem [DEPTH];
  logic [lfw_pkg::CHAR_W-1:0] rdata;

  // decision terms for the captured character
  logic [COLW-1:0] w_eff, thr, thr_m1, colp;
  logic            blank_cur, hc_full, pass, fold, bseen_new;
  logic [CW-1:0]   hc_new, brel_new, t_new, e_new, cnt_init;
  logic [SW-1:0]   wsum;
  logic [IW-1:0]   waddr;

  always_comb begin
    w_eff     = (line_width < DEPTH_C) ? DEPTH_C : line_width;
    thr       = w_eff - WIN_C;
    thr_m1    = thr - COLW'(1);
    colp      = (col == {COLW{1'b1}}) ? col : col + COLW'(1);
    pass      = !wact && (colp < thr);
    blank_cur = (cur == lfw_pkg::CH_BLANK) || (cur == lfw_pkg::CH_TAB);
    hc_full   = (hc == FULL_C);
    hc_new    = hc_full ? hc : hc + CW'(1);
    brel_new  = blank_cur ? hc : brel;
    bseen_new = bseen || blank_cur;
    fold      = (colp >= w_eff) || (hc_new == FULL_C);
    t_new     = bseen_new ? (hc_new - brel_new - CW'(1)) : CW'(1);
    e_new     = (COLW'(t_new) < thr_m1) ? t_new : CW'(thr_m1);
    if (cur == lfw_pkg::CH_NEWLINE) begin
      cnt_init = hc;
    end else if (bseen_new) begin
      cnt_init = brel_new;
    end else begin
      cnt_init = hc_new - CW'(1);
    end
    wsum  = SW'(hd) + SW'(hc);
    waddr = (wsum >= SW'(DEPTH)) ? IW'(wsum - SW'(DEPTH)) : IW'(wsum);
  end

  // status
  always_comb begin
    stat.is_nl      = (cur == lfw_pkg::CH_NEWLINE);
    stat.pass       = pass;
    stat.fold       = fold;
    stat.fold_blank = bseen_new;
    stat.cnt_zero   = (cnt == '0);
    stat.cnt_one    = (cnt == CW'(1));
    stat.e_zero     = (e_reg == '0);
    stat.out_free   = !out_valid || out_ready;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= lfw_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we) begin
      line_width <= cfg_wdata;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      cur <= in_char;
    end
  end

  // buffer write on hold, registered read at the head
  always_ff @(posedge clk) begin
    if (cmd.step && !stat.is_nl && !pass && !hc_full) begin
      mem[waddr] <= cur;
    end
    if (cmd.rd) begin
      rdata <= mem[hd];
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      wact  <= 1'b0;
      hd    <= '0;
      hc    <= '0;
      brel  <= '0;
      bseen <= 1'b0;
      cnt   <= '0;
    end else begin
      if (cmd.step) begin
        cnt <= cnt_init;
        if (!stat.is_nl) begin
          col <= colp;
          if (!pass) begin
            wact  <= 1'b1;
            hc    <= hc_new;
            brel  <= brel_new;
            bseen <= bseen_new;
          end
        end
      end
      if (cmd.pop) begin
        hd <= (hd == IW'(DEPTH - 1)) ? '0 : hd + IW'(1);
        hc <= hc - CW'(1);
      end
      if (cmd.cnt_dec) begin
        cnt <= cnt - CW'(1);
      end
      if (cmd.cnt_ld_e) begin
        cnt <= e_reg;
      end
      // carried tail starts the new line
      if (cmd.fold_fin) begin
        col   <= COLW'(t_reg);
        wact  <= (COLW'(t_reg) >= thr);
        brel  <= '0;
        bseen <= 1'b0;
      end
      if (cmd.clear) begin
        col   <= '0;
        wact  <= 1'b0;
        hc    <= '0;
        brel  <= '0;
        bseen <= 1'b0;
      end
    end
  end

  // tail length and emitted part, captured at the decision
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      t_reg <= t_new;
      e_reg <= e_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_buf || cmd.ld_sym) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_buf) begin
      out_char <= rdata;
      out_last <= cmd.out_last;
    end else if (cmd.ld_sym) begin
      case (cmd.sym_sel)
        lfw_pkg::SYM_NL: out_char <= lfw_pkg::CH_NEWLINE;
        lfw_pkg::SYM_HY: out_char <= lfw_pkg::CH_HYPHEN;
        default:         out_char <= cur;
      endcase
      out_last <= cmd.out_last;
    end
  end

endmodule
